// ===== design/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI cursor parser package
// Shared widths, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int PARAM_WIDTH = 16;
  localparam int VALUE_WIDTH = PARAM_WIDTH + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_HOME  = 8'h48;

  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_REL   = 2'd1;
  localparam logic [1:0] KIND_ABS   = 2'd2;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_UP,
    OP_DOWN,
    OP_RIGHT,
    OP_LEFT,
    OP_HOME,
    OP_ABS
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [7:0]             ch;
    logic [PARAM_WIDTH-1:0] p1;
    logic [PARAM_WIDTH-1:0] p2;
  } cmd_t;

endpackage

// ===== design/acp_front.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI cursor parser front end
// Tracks the escape state, builds parameters and issues one command per result.
// ----------------------------------------------------------------------------
module acp_front import acp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_CSI   = 2'd2;
  localparam logic [1:0] MODE_OTHER = 2'd3;
  localparam int         PROD_WIDTH = PARAM_WIDTH + 4;
  localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = {PARAM_WIDTH{1'b1}};

  logic [1:0]             parse_mode, parse_mode_next;
  logic [PARAM_WIDTH-1:0] digit_accum, digit_accum_next;
  logic                   digits_pending, digits_pending_next;
  logic [1:0]             param_count, param_count_next;
  logic [PARAM_WIDTH-1:0] first_param, first_param_next;
  logic [PARAM_WIDTH-1:0] second_param, second_param_next;

  logic                   is_letter, is_digit;
  logic [PROD_WIDTH-1:0]  accum_ext, accum_sum;
  logic [1:0]             end_count;
  logic [PARAM_WIDTH-1:0] end_first, end_second;
  logic [1:0]             fin_count;
  logic [PARAM_WIDTH-1:0] fin_first, fin_second, amount;

  always_comb begin
    is_letter = (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
                (byte_in >= 8'h61 && byte_in <= 8'h7A);
    is_digit  = (byte_in >= 8'h30 && byte_in <= 8'h39);
    accum_ext = {4'b0, digit_accum};
    accum_sum = (accum_ext << 3) + (accum_ext << 1) +
                {{(PROD_WIDTH-4){1'b0}}, byte_in[3:0]};

    end_first  = (param_count == 2'd0) ? digit_accum : first_param;
    end_second = (param_count == 2'd1) ? digit_accum : second_param;
    end_count  = (param_count == 2'd3) ? param_count : param_count + 2'd1;

    fin_first  = digits_pending ? end_first  : first_param;
    fin_second = digits_pending ? end_second : second_param;
    fin_count  = digits_pending ? end_count  : param_count;
    amount     = (fin_count == 2'd0) ? {{(PARAM_WIDTH-1){1'b0}}, 1'b1} : fin_first;
  end

  always_comb begin
    parse_mode_next     = parse_mode;
    digit_accum_next    = digit_accum;
    digits_pending_next = digits_pending;
    param_count_next    = param_count;
    first_param_next    = first_param;
    second_param_next   = second_param;
    cmd_valid           = 1'b0;
    cmd.op              = OP_PRINT;
    cmd.ch              = byte_in;
    cmd.p1              = amount;
    cmd.p2              = fin_second;
    case (parse_mode)
      MODE_IDLE: begin
        if (byte_in == CH_ESC) begin
          parse_mode_next     = MODE_ESC;
          digit_accum_next    = '0;
          digits_pending_next = 1'b0;
          param_count_next    = 2'd0;
          first_param_next    = '0;
          second_param_next   = '0;
        end else begin
          cmd_valid = 1'b1;
        end
      end
      MODE_ESC: begin
        if (byte_in == CH_LBRKT) parse_mode_next = MODE_CSI;
        else if (is_letter)      parse_mode_next = MODE_IDLE;
        else                     parse_mode_next = MODE_OTHER;
      end
      MODE_CSI: begin
        if (is_letter) begin
          parse_mode_next     = MODE_IDLE;
          digit_accum_next    = '0;
          digits_pending_next = 1'b0;
          param_count_next    = 2'd0;
          first_param_next    = '0;
          second_param_next   = '0;
          case (byte_in)
            CH_UP:    begin cmd_valid = 1'b1; cmd.op = OP_UP;    end
            CH_DOWN:  begin cmd_valid = 1'b1; cmd.op = OP_DOWN;  end
            CH_RIGHT: begin cmd_valid = 1'b1; cmd.op = OP_RIGHT; end
            CH_LEFT:  begin cmd_valid = 1'b1; cmd.op = OP_LEFT;  end
            CH_HOME: begin
              cmd_valid = 1'b1;
              cmd.op    = (fin_count >= 2'd2) ? OP_ABS : OP_HOME;
              cmd.p1    = fin_first;
            end
            default: cmd_valid = 1'b0;
          endcase
        end else if (is_digit) begin
          digit_accum_next    = (|accum_sum[PROD_WIDTH-1:PARAM_WIDTH]) ? PARAM_MAX :
                                accum_sum[PARAM_WIDTH-1:0];
          digits_pending_next = 1'b1;
        end else if (byte_in == CH_SEMI) begin
          first_param_next    = end_first;
          second_param_next   = end_second;
          param_count_next    = end_count;
          digit_accum_next    = '0;
          digits_pending_next = 1'b0;
        end
      end
      default: begin
        if (is_letter) parse_mode_next = MODE_IDLE;
      end
    endcase
    if (!accept) cmd_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode     <= MODE_IDLE;
      digit_accum    <= '0;
      digits_pending <= 1'b0;
      param_count    <= 2'd0;
      first_param    <= '0;
      second_param   <= '0;
    end else if (accept) begin
      parse_mode     <= parse_mode_next;
      digit_accum    <= digit_accum_next;
      digits_pending <= digits_pending_next;
      param_count    <= param_count_next;
      first_param    <= first_param_next;
      second_param   <= second_param_next;
    end
  end

endmodule

// ===== design/acp_queue.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI cursor parser command queue
// Short register queue decoupling the front end from the result stage.
// ----------------------------------------------------------------------------
module acp_queue import acp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                  mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr, rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_push, do_pop;

  assign full    = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/acp_back.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI cursor parser back end
// Turns queued commands into signed cursor values in the output register.
// ----------------------------------------------------------------------------
module acp_back import acp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [1:0]             result_kind,
  output logic [7:0]             print_char,
  output logic signed [VALUE_WIDTH-1:0] row_value,
  output logic signed [VALUE_WIDTH-1:0] col_value
);

  logic                          out_valid;
  logic                          load;
  logic [1:0]                    kind_next;
  logic [7:0]                    char_next;
  logic signed [VALUE_WIDTH-1:0] row_next, col_next, amt, amt_neg, p1_m1, p2_m1;

  assign empty   = !out_valid;
  assign load    = !cmd_empty && (!out_valid || pop);
  assign cmd_pop = load;

  always_comb begin
    amt     = {1'b0, cmd.p1};
    amt_neg = -amt;
    p1_m1   = {1'b0, cmd.p1} - VALUE_WIDTH'(1);
    p2_m1   = {1'b0, cmd.p2} - VALUE_WIDTH'(1);
    kind_next = KIND_REL;
    char_next = 8'd0;
    row_next  = '0;
    col_next  = '0;
    case (cmd.op)
      OP_PRINT: begin kind_next = KIND_PRINT; char_next = cmd.ch; end
      OP_UP:    row_next = amt_neg;
      OP_DOWN:  row_next = amt;
      OP_RIGHT: col_next = amt;
      OP_LEFT:  col_next = amt_neg;
      OP_HOME:  kind_next = KIND_ABS;
      OP_ABS: begin
        kind_next = KIND_ABS;
        row_next  = p1_m1;
        col_next  = p2_m1;
      end
      default: kind_next = KIND_REL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= kind_next;
      print_char  <= char_next;
      row_value   <= row_next;
      col_value   <= col_next;
    end
  end

endmodule

// ===== design/ansi_csi_cursor_parser.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI cursor parser
// Byte stream in, print characters and cursor move commands out.
//
//   channel   handshake      payload
//   request   push / full    byte_in[7:0]
//   result    pop / empty    result_kind[1:0], print_char[7:0],
//                            row_value[16:0], col_value[16:0]
//
// One byte is taken per cycle while full is low; a result passes from the front
// end through a two-entry command queue into the output register.
// Reset clears the parse state, the queue and the output register's valid flag.
// A stalled consumer fills the queue; full then rises and holds the input.
// ----------------------------------------------------------------------------
module ansi_csi_cursor_parser import acp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    byte_in,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    result_kind,
  output logic [7:0]                    print_char,
  output logic signed [VALUE_WIDTH-1:0] row_value,
  output logic signed [VALUE_WIDTH-1:0] col_value
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd_in, cmd_out;
  logic q_empty, q_pop;

  assign accept = push && !full;

  acp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_in   (byte_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  acp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .din   (cmd_in),
    .full  (full),
    .pop   (q_pop),
    .dout  (cmd_out),
    .empty (q_empty)
  );

  acp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_out),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .result_kind (result_kind),
    .print_char  (print_char),
    .row_value   (row_value),
    .col_value   (col_value)
  );

endmodule

// ===== tb/cursor_command_checker.sv =====
// ----------------------------------------------------------------------------
// Cursor command checker
// Watches the byte and result queues of the ANSI CSI cursor parser. It keeps
// its own copy of the parse state, works out the command that each accepted
// byte should give, and compares each popped result with the oldest one.
// ----------------------------------------------------------------------------
module cursor_command_checker import acp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [7:0]                    byte_in,
  input  logic                          pop,
  input  logic                          empty,
  input  logic [1:0]                    result_kind,
  input  logic [7:0]                    print_char,
  input  logic signed [VALUE_WIDTH-1:0] row_value,
  input  logic signed [VALUE_WIDTH-1:0] col_value,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARAM_MAX = (1 << PARAM_WIDTH) - 1;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_CSI,
    MODE_SKIP
  } parse_mode_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [7:0]                    ch;
    logic signed [VALUE_WIDTH-1:0] row;
    logic signed [VALUE_WIDTH-1:0] col;
  } cursor_cmd_t;

  parse_mode_t mode = MODE_TEXT;
  int          accum;
  bit          digits_seen;
  int          params_ended;
  int          first_p;
  int          second_p;
  int          fails = 0;
  cursor_cmd_t expected_cmds [$];

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic void clear_params();
    accum        = 0;
    digits_seen  = 1'b0;
    params_ended = 0;
    first_p      = 0;
    second_p     = 0;
  endfunction

  function automatic void close_param();
    if (params_ended == 0) begin
      first_p = accum;
    end else if (params_ended == 1) begin
      second_p = accum;
    end
    if (params_ended < 3) begin
      params_ended++;
    end
    accum       = 0;
    digits_seen = 1'b0;
  endfunction

  function automatic void queue_cmd(logic [1:0] kind, logic [7:0] ch, int row, int col);
    cursor_cmd_t c;
    c.kind = kind;
    c.ch   = ch;
    c.row  = VALUE_WIDTH'(row);
    c.col  = VALUE_WIDTH'(col);
    expected_cmds.insert(expected_cmds.size(), c);
  endfunction

  function automatic void finish_sequence(logic [7:0] b);
    int amount;
    if (digits_seen) begin
      close_param();
    end
    amount = (params_ended == 0) ? 1 : first_p;
    case (b)
      CH_UP:    queue_cmd(KIND_REL, 8'h00, -amount, 0);
      CH_DOWN:  queue_cmd(KIND_REL, 8'h00, amount, 0);
      CH_RIGHT: queue_cmd(KIND_REL, 8'h00, 0, amount);
      CH_LEFT:  queue_cmd(KIND_REL, 8'h00, 0, -amount);
      CH_HOME: begin
        if (params_ended >= 2) begin
          queue_cmd(KIND_ABS, 8'h00, first_p - 1, second_p - 1);
        end else begin
          queue_cmd(KIND_ABS, 8'h00, 0, 0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int digit;
    case (mode)
      MODE_TEXT: begin
        if (b == CH_ESC) begin
          clear_params();
          mode = MODE_ESC;
        end else begin
          queue_cmd(KIND_PRINT, b, 0, 0);
        end
      end
      MODE_ESC: begin
        if (b == CH_LBRKT) begin
          mode = MODE_CSI;
        end else if (is_letter(b)) begin
          mode = MODE_TEXT;
        end else begin
          mode = MODE_SKIP;
        end
      end
      MODE_CSI: begin
        if (is_letter(b)) begin
          finish_sequence(b);
          mode = MODE_TEXT;
          clear_params();
        end else if (b >= "0" && b <= "9") begin
          digit       = int'(b) - int'("0");
          accum       = accum * 10 + digit;
          if (accum > PARAM_MAX) begin
            accum = PARAM_MAX;
          end
          digits_seen = 1'b1;
        end else if (b == CH_SEMI) begin
          close_param();
        end
      end
      default: begin
        if (is_letter(b)) begin
          mode = MODE_TEXT;
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    cursor_cmd_t want;
    if (rst) begin
      mode = MODE_TEXT;
      clear_params();
      expected_cmds.delete();
    end else begin
      if (push && !full) begin
        predict_byte(byte_in);
      end
      if (pop && !empty) begin
        if (expected_cmds.size() == 0) begin
          $error("result_kind: expected no result, actual %0d", result_kind);
          fails++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("print_char", want.ch, print_char);
          check_field("row_value", want.row, row_value);
          check_field("col_value", want.col, col_value);
        end
      end
    end
    fail_count    <= fails;
    pending_count <= expected_cmds.size();
  end

endmodule

// ===== tb/ansi_csi_cursor_parser_test.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI cursor parser testbench
// Feeds directed and random terminal byte streams, mostly well-formed cursor
// sequences with random parameters, under several idle and stall patterns,
// and leaves the result checking to the cursor command checker.
// ----------------------------------------------------------------------------
module ansi_csi_cursor_parser_test import acp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTES_PER_PHASE = 340;

  logic                          clk;
  logic                          rst     = 1'b1;
  logic                          push    = 1'b0;
  logic                          full;
  logic [7:0]                    byte_in = 8'h00;
  logic                          pop     = 1'b0;
  logic                          empty;
  logic [1:0]                    result_kind;
  logic [7:0]                    print_char;
  logic signed [VALUE_WIDTH-1:0] row_value;
  logic signed [VALUE_WIDTH-1:0] col_value;

  int fail_count;
  int pending_count;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int bytes_sent   = 0;

  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'hFF,
    CH_ESC, CH_LBRKT, "9", "9", "9", "9", "9", CH_LEFT,
    CH_ESC, CH_LBRKT, CH_SEMI, CH_SEMI, "7", CH_HOME,
    CH_ESC, CH_LBRKT, "1", CH_ESC, "2", CH_UP,
    CH_ESC, CH_LBRKT, CH_RIGHT,
    CH_ESC, 8'h5D, "x",
    CH_ESC, CH_LBRKT, "h"
  };

  ansi_csi_cursor_parser dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .byte_in     (byte_in),
    .pop         (pop),
    .empty       (empty),
    .result_kind (result_kind),
    .print_char  (print_char),
    .row_value   (row_value),
    .col_value   (col_value)
  );

  cursor_command_checker cmd_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .byte_in       (byte_in),
    .pop           (pop),
    .empty         (empty),
    .result_kind   (result_kind),
    .print_char    (print_char),
    .row_value     (row_value),
    .col_value     (col_value),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      push    <= 1'b0;
      byte_in <= 8'($urandom);
      @(posedge clk);
    end
    push    <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  function automatic logic [7:0] stray_byte();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'h2F, 8'h00));
      1:       return $urandom_range(1) ? 8'h3A : 8'($urandom_range(8'h40, 8'h3C));
      2:       return 8'($urandom_range(8'h60, 8'h5B));
      default: return 8'($urandom_range(8'hFF, 8'h7B));
    endcase
  endfunction

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(25);
    return $urandom_range(1) ? 8'(int'("a") + r) : 8'(int'("A") + r);
  endfunction

  task automatic send_parameter();
    int r;
    int n;
    r = $urandom_range(9);
    if (r == 0) begin
      n = 0;
    end else if (r <= 6) begin
      n = $urandom_range(3, 1);
    end else if (r <= 8) begin
      n = $urandom_range(5, 4);
    end else begin
      n = $urandom_range(7, 6);
    end
    repeat (n) begin
      if ($urandom_range(15) == 0) begin
        send_byte(stray_byte());
      end
      send_byte(8'(int'("0") + $urandom_range(9)));
    end
  endtask

  task automatic send_csi();
    int nparams;
    nparams = $urandom_range(3);
    send_byte(CH_ESC);
    send_byte(CH_LBRKT);
    for (int i = 0; i < nparams; i++) begin
      if (i != 0) begin
        send_byte(CH_SEMI);
      end
      send_parameter();
    end
    case ($urandom_range(9))
      0, 1:    send_byte(CH_UP);
      2, 3:    send_byte(CH_DOWN);
      4:       send_byte(CH_RIGHT);
      5:       send_byte(CH_LEFT);
      6, 7, 8: send_byte(CH_HOME);
      default: send_byte(any_letter());
    endcase
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: begin
        send_byte(CH_ESC);
        repeat ($urandom_range(3)) send_byte(stray_byte());
        send_byte(any_letter());
      end
      1: begin
        send_byte(CH_ESC);
        send_byte(any_letter());
      end
      2: send_byte(8'($urandom));
      default: begin
        send_byte(CH_ESC);
        send_byte(CH_LBRKT);
        send_parameter();
        send_byte(CH_ESC);
        send_parameter();
        send_byte(any_letter());
      end
    endcase
  endtask

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 76; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 76; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      while (bytes_sent < BYTES_PER_PHASE * (phase + 1) + directed_bytes.size()) begin
        r = $urandom_range(99);
        if (r < 40) begin
          send_byte(8'($urandom));
        end else if (r < 85) begin
          send_csi();
        end else begin
          send_noise();
        end
      end
    end
    push <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
